/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the snapshot manager RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DBSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dbsm_pkg.sv */
// ----------------------------------------------------------------------------
// dbsm_pkg
// Types and constants shared by the double buffer snapshot manager modules.
// ----------------------------------------------------------------------------
package dbsm_pkg;

   localparam int CMD_W   = 3;
   localparam int DSIZE_W = 16;
   localparam int CAP_W   = 13;
   localparam int SEQ_W   = 32;
   localparam int STAMP_W = 32;
   localparam int STAT_W  = 3;
   localparam int APB_DW  = 32;
   localparam int APB_AW  = 3;

   // physical bytes per slot; the programmed capacity is clipped to this
   localparam logic [DSIZE_W-1:0] SLOT_BYTES = 16'd4096;

   // register index, taken from the word address
   localparam logic REG_SLOT_CAPACITY = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN   = 3'd0,
      CMD_PUBLISH = 3'd1,
      CMD_CANCEL  = 3'd2,
      CMD_ACQUIRE = 3'd3,
      CMD_RELEASE = 3'd4,
      CMD_QUERY   = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_INIT  = 3'd1,
      ST_BUSY      = 3'd2,
      ST_INVALID   = 3'd3,
      ST_TOO_SMALL = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   // registered request
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [DSIZE_W-1:0] data_size;
      logic [STAMP_W-1:0] stamp;
      logic               lease_slot;
      logic [SEQ_W-1:0]   lease_sequence;
   } req_type;

   // csr -> engine
   typedef struct packed {
      logic               reinit;
      logic               initialized;
      logic [DSIZE_W-1:0] cap_eff;
   } cfg_type;

   // engine -> csr
   typedef struct packed {
      logic writer_busy;
      logic lease_open;
   } eng_stat_type;

endpackage

/* rtl/dbsm_req_stage.sv */
// ----------------------------------------------------------------------------
// dbsm_req_stage
// Input register: captures each accepted request for the command engine.
// ----------------------------------------------------------------------------
module dbsm_req_stage import dbsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_type             req_in,
   output logic                req_valid,
   output req_type             req_out
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;

   assign valid_in = accept;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   assign req_valid = valid_ff;
   assign req_out   = req_ff;

endmodule

/* rtl/dbsm_csr.sv */
// ----------------------------------------------------------------------------
// dbsm_csr
// APB register file holding slot_capacity and deciding re-initialization.
// ----------------------------------------------------------------------------
module dbsm_csr import dbsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [APB_AW-1:0]   paddr,
   input  logic [APB_DW-1:0]   pwdata,
   output logic [APB_DW-1:0]   prdata,
   output logic                pready,
   input  eng_stat_type        stat,
   output cfg_type             cfg
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_hit;
   logic             reinit;

   // write to slot_capacity: nonzero and nothing outstanding
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_SLOT_CAPACITY);
   assign reinit = wr_hit && (pwdata[CAP_W-1:0] != '0)
                   && !stat.writer_busy && !stat.lease_open;

   assign capacity_in = reinit ? pwdata[CAP_W-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // effective capacity clipped to the physical slot size
   always_comb begin
      cfg.reinit      = reinit;
      cfg.initialized = (capacity_ff != '0);
      if ({{(DSIZE_W-CAP_W){1'b0}}, capacity_ff} > SLOT_BYTES) begin
         cfg.cap_eff = SLOT_BYTES;
      end else begin
         cfg.cap_eff = {{(DSIZE_W-CAP_W){1'b0}}, capacity_ff};
      end
   end

   // read back
   assign prdata = (paddr[2] == REG_SLOT_CAPACITY) ?
                   {{(APB_DW-CAP_W){1'b0}}, capacity_ff} : '0;
   assign pready = 1'b1;

endmodule

/* rtl/dbsm_engine.sv */
// ----------------------------------------------------------------------------
// dbsm_engine
// Ownership state of both slots, command decode and the result register.
// ----------------------------------------------------------------------------
module dbsm_engine import dbsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  req_type             req,
   input  cfg_type             cfg,
   output eng_stat_type        stat,
   output logic                rsp_valid,
   output logic [STAT_W-1:0]   rsp_status,
   output logic                rsp_granted_slot,
   output logic [CAP_W-1:0]    rsp_size_out,
   output logic [SEQ_W-1:0]    rsp_seq_out,
   output logic [STAMP_W-1:0]  rsp_stamp_out
);

   // ownership state
   logic               has_published_ff, has_published_in;
   logic               active_slot_ff,   active_slot_in;
   logic               writing_slot_ff,  writing_slot_in;
   logic               writer_busy_ff,   writer_busy_in;
   logic [1:0]         reader_held_ff,   reader_held_in;
   logic [CAP_W-1:0]   slot_size_ff  [2];
   logic [CAP_W-1:0]   slot_size_in  [2];
   logic [SEQ_W-1:0]   slot_seq_ff   [2];
   logic [SEQ_W-1:0]   slot_seq_in   [2];
   logic [STAMP_W-1:0] slot_stamp_ff [2];
   logic [STAMP_W-1:0] slot_stamp_in [2];

   // result register
   logic               rsp_valid_ff;
   status_type         status_ff,  status_in;
   logic               granted_ff, granted_in;
   logic [CAP_W-1:0]   size_ff,    size_in;
   logic [SEQ_W-1:0]   seq_ff,     seq_in;
   logic [STAMP_W-1:0] stamp_ff,   stamp_in;

   // helpers
   logic               begin_slot;
   logic [SEQ_W-1:0]   cur_seq;
   logic               rel_match;

   assign begin_slot = has_published_ff ? ~active_slot_ff : 1'b0;
   assign cur_seq    = has_published_ff ? slot_seq_ff[active_slot_ff] : '0;
   assign rel_match  = reader_held_ff[req.lease_slot]
                       && (req.data_size == {{(DSIZE_W-CAP_W){1'b0}},
                                             slot_size_ff[req.lease_slot]})
                       && (req.lease_sequence == slot_seq_ff[req.lease_slot])
                       && (req.stamp == slot_stamp_ff[req.lease_slot]);

   // command decode and next state
   always_comb begin
      has_published_in = has_published_ff;
      active_slot_in   = active_slot_ff;
      writing_slot_in  = writing_slot_ff;
      writer_busy_in   = writer_busy_ff;
      reader_held_in   = reader_held_ff;
      slot_size_in     = slot_size_ff;
      slot_seq_in      = slot_seq_ff;
      slot_stamp_in    = slot_stamp_ff;
      status_in        = ST_OK;
      granted_in       = 1'b0;
      size_in          = '0;
      seq_in           = '0;
      stamp_in         = '0;

      if (!cfg.initialized) begin
         status_in = ST_NOT_INIT;
      end else begin
         unique case (req.cmd)
            CMD_BEGIN: begin
               if (writer_busy_ff || reader_held_ff[begin_slot]) begin
                  status_in = ST_BUSY;
               end else begin
                  writing_slot_in = begin_slot;
                  writer_busy_in  = 1'b1;
                  granted_in      = begin_slot;
               end
            end
            CMD_PUBLISH: begin
               if (!writer_busy_ff) begin
                  status_in = ST_INVALID;
               end else if (req.data_size > cfg.cap_eff) begin
                  status_in = ST_TOO_SMALL;
               end else if (cur_seq == '1) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  slot_size_in[writing_slot_ff]  = req.data_size[CAP_W-1:0];
                  slot_seq_in[writing_slot_ff]   = cur_seq + 1'b1;
                  slot_stamp_in[writing_slot_ff] = req.stamp;
                  active_slot_in   = writing_slot_ff;
                  has_published_in = 1'b1;
                  writer_busy_in   = 1'b0;
               end
            end
            CMD_CANCEL: begin
               if (!writer_busy_ff) begin
                  status_in = ST_INVALID;
               end else begin
                  writer_busy_in = 1'b0;
               end
            end
            CMD_ACQUIRE: begin
               if (!has_published_ff) begin
                  status_in = ST_EMPTY;
               end else if (reader_held_ff[active_slot_ff]) begin
                  status_in = ST_BUSY;
               end else begin
                  reader_held_in[active_slot_ff] = 1'b1;
                  granted_in = active_slot_ff;
                  size_in    = slot_size_ff[active_slot_ff];
                  seq_in     = slot_seq_ff[active_slot_ff];
                  stamp_in   = slot_stamp_ff[active_slot_ff];
               end
            end
            CMD_RELEASE: begin
               if (!rel_match) begin
                  status_in = ST_INVALID;
               end else begin
                  reader_held_in[req.lease_slot] = 1'b0;
               end
            end
            CMD_QUERY: begin
               if (!has_published_ff) begin
                  status_in = ST_EMPTY;
               end else begin
                  size_in  = slot_size_ff[active_slot_ff];
                  seq_in   = slot_seq_ff[active_slot_ff];
                  stamp_in = slot_stamp_ff[active_slot_ff];
               end
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end
   end

   // state update; an accepted capacity write clears everything
   always_ff @(posedge clock) begin
      if (reset || cfg.reinit) begin
         has_published_ff <= 1'b0;
         active_slot_ff   <= 1'b0;
         writing_slot_ff  <= 1'b0;
         writer_busy_ff   <= 1'b0;
         reader_held_ff   <= '0;
         for (int i = 0; i < 2; i++) begin
            slot_size_ff[i]  <= '0;
            slot_seq_ff[i]   <= '0;
            slot_stamp_ff[i] <= '0;
         end
      end else if (req_valid) begin
         has_published_ff <= has_published_in;
         active_slot_ff   <= active_slot_in;
         writing_slot_ff  <= writing_slot_in;
         writer_busy_ff   <= writer_busy_in;
         reader_held_ff   <= reader_held_in;
         slot_size_ff     <= slot_size_in;
         slot_seq_ff      <= slot_seq_in;
         slot_stamp_ff    <= slot_stamp_in;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_valid) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         size_ff    <= size_in;
         seq_ff     <= seq_in;
         stamp_ff   <= stamp_in;
      end
   end

   assign stat.writer_busy = writer_busy_ff;
   assign stat.lease_open  = |reader_held_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_size_out     = size_ff;
   assign rsp_seq_out      = seq_ff;
   assign rsp_stamp_out    = stamp_ff;

endmodule

/* rtl/double_buffer_snapshot_manager.sv */
// A request is captured in the input register, then its result is registered in the result register and strobed.
// Throughput: one request per cycle; busy is never raised, set by the single-pass decode.
// Results are shown for one cycle only; the receiver cannot stall.
// Reset (synchronous, active high) clears capacity, slot ownership and metadata.
// ----------------------------------------------------------------------------
// double_buffer_snapshot_manager
// Ownership controller for a two-slot ping-pong snapshot store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_buffer_snapshot_manager import dbsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [DSIZE_W-1:0]  req_data_size,
   input  logic [STAMP_W-1:0]  req_stamp,
   input  logic                req_lease_slot,
   input  logic [SEQ_W-1:0]    req_lease_sequence,
   // result channel
   output logic                rsp_valid,
   output logic [STAT_W-1:0]   rsp_status,
   output logic                rsp_granted_slot,
   output logic [CAP_W-1:0]    rsp_size_out,
   output logic [SEQ_W-1:0]    rsp_seq_out,
   output logic [STAMP_W-1:0]  rsp_stamp_out,
   // configuration
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [APB_AW-1:0]   paddr,
   input  logic [APB_DW-1:0]   pwdata,
   output logic [APB_DW-1:0]   prdata,
   output logic                pready
);

   req_type      req_in;
   req_type      req_q;
   logic         req_valid;
   cfg_type      cfg;
   eng_stat_type stat;

   assign busy = 1'b0;

   assign req_in.cmd            = req_cmd;
   assign req_in.data_size      = req_data_size;
   assign req_in.stamp          = req_stamp;
   assign req_in.lease_slot     = req_lease_slot;
   assign req_in.lease_sequence = req_lease_sequence;

   dbsm_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .req_in    (req_in),
      .req_valid (req_valid),
      .req_out   (req_q)
   );

   dbsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .stat    (stat),
      .cfg     (cfg)
   );

   dbsm_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req              (req_q),
      .cfg              (cfg),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_size_out     (rsp_size_out),
      .rsp_seq_out      (rsp_seq_out),
      .rsp_stamp_out    (rsp_stamp_out)
   );

   // one result for every accepted request, through the input register and the result register
   `DBSM_ASSERT_NOW(a_one_result, clock, reset, 1'b1, rsp_valid == ($past(start, 2) && !$past(busy, 2) && !$past(reset, 1) && !$past(reset, 2)), "result strobe does not match accepted requests")
   // re-initialization leaves no writer and no lease open
   `DBSM_ASSERT_NEXT(a_reinit_clear, clock, reset, cfg.reinit, !stat.writer_busy && !stat.lease_open, "state not cleared after capacity write")
   // re-initialization always leaves the block initialized
   `DBSM_ASSERT_NEXT(a_reinit_cap, clock, reset, cfg.reinit, cfg.initialized, "capacity zero after re-initialization")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot manager testbench
// Drives begin/publish/cancel/acquire/release/query requests and capacity
// writes into the ping-pong snapshot manager. A local ownership predictor
// works out the result of each accepted request. Results are compared
// field by field, in order, with the predicted or tabled ones.
// ----------------------------------------------------------------------------
module testbench;
   import dbsm_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_SPARE_6   = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_SPARE_7   = 3'd7;
   localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_SLOT_CAPACITY, 2'b00};
   localparam logic [APB_AW-1:0] SPARE_ADDR    = {~REG_SLOT_CAPACITY, 2'b00};
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 250;

   typedef struct packed {
      status_type         status;
      logic               granted;
      logic [CAP_W-1:0]   size;
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
   } outcome_type;

   typedef struct {
      req_type     req;
      bit          typed;
      outcome_type want;
   } stim_row_type;

   // DUT connections
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [DSIZE_W-1:0]  req_data_size = '0;
   logic [STAMP_W-1:0]  req_stamp = '0;
   logic                req_lease_slot = 1'b0;
   logic [SEQ_W-1:0]    req_lease_sequence = '0;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_granted_slot;
   logic [CAP_W-1:0]    rsp_size_out;
   logic [SEQ_W-1:0]    rsp_seq_out;
   logic [STAMP_W-1:0]  rsp_stamp_out;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [APB_AW-1:0]   paddr = '0;
   logic [APB_DW-1:0]   pwdata = '0;
   logic [APB_DW-1:0]   prdata;
   logic                pready;

   // predictor copy of the ownership state
   logic [CAP_W-1:0]   capacity_reg;
   logic               published;
   logic               live_slot;
   logic               fill_slot;
   logic               writer_open;
   logic               lease_open [2];
   logic [CAP_W-1:0]   meta_size [2];
   logic [SEQ_W-1:0]   meta_seq [2];
   logic [STAMP_W-1:0] meta_stamp [2];

   outcome_type  awaited_outcomes [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           idle_on = 1'b1;

   double_buffer_snapshot_manager uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_data_size      (req_data_size),
      .req_stamp          (req_stamp),
      .req_lease_slot     (req_lease_slot),
      .req_lease_sequence (req_lease_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_slot   (rsp_granted_slot),
      .rsp_size_out       (rsp_size_out),
      .rsp_seq_out        (rsp_seq_out),
      .rsp_stamp_out      (rsp_stamp_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("double_buffer_snapshot_manager verification failed");
         $finish;
      end
   end

   task automatic report_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", name, want_v, got_v);
      end
   endtask

   // compare each strobed result with the oldest outstanding request
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (awaited_outcomes.size() == 0) begin
            report_field("unexpected result status", '0, rsp_status);
            mismatch_count += (rsp_status === '0) ? 1 : 0;
         end else begin
            want = awaited_outcomes.pop_front();
            report_field("status", want.status, rsp_status);
            report_field("granted_slot", want.granted, rsp_granted_slot);
            report_field("size_out", want.size, rsp_size_out);
            report_field("seq_out", want.seq, rsp_seq_out);
            report_field("stamp_out", want.stamp, rsp_stamp_out);
         end
      end
   end

   function automatic void clear_snapshot_state();
      published   = 1'b0;
      live_slot   = 1'b0;
      fill_slot   = 1'b0;
      writer_open = 1'b0;
      for (int s = 0; s < 2; s++) begin
         lease_open[s] = 1'b0;
         meta_size[s]  = '0;
         meta_seq[s]   = '0;
         meta_stamp[s] = '0;
      end
   endfunction

   function automatic logic [DSIZE_W-1:0] effective_capacity();
      return (capacity_reg > SLOT_BYTES) ? SLOT_BYTES : DSIZE_W'(capacity_reg);
   endfunction

   // capacity write: ignored when zero, on another register, or with work open
   function automatic void apply_register_write(input logic [APB_AW-1:0] addr,
                                                input logic [APB_DW-1:0] data);
      logic [CAP_W-1:0] v;
      v = data[CAP_W-1:0];
      if (addr[APB_AW-1:2] != REG_SLOT_CAPACITY || v == '0 || writer_open ||
          lease_open[0] || lease_open[1])
         return;
      clear_snapshot_state();
      capacity_reg = v;
   endfunction

   // ownership predictor: result of one request, state updated in place
   function automatic outcome_type snapshot_outcome(input req_type r);
      outcome_type        o;
      logic               pick;
      logic [SEQ_W-1:0]   last_seq;
      logic               ls;
      o = '0;
      o.status = ST_OK;
      ls = r.lease_slot;
      if (capacity_reg == '0) begin
         o.status = ST_NOT_INIT;
      end else begin
         case (r.cmd)
            CMD_BEGIN: begin
               pick = published ? ~live_slot : 1'b0;
               if (writer_open || lease_open[pick]) begin
                  o.status = ST_BUSY;
               end else begin
                  fill_slot   = pick;
                  writer_open = 1'b1;
                  o.granted   = pick;
               end
            end
            CMD_PUBLISH: begin
               last_seq = published ? meta_seq[live_slot] : '0;
               if (!writer_open)
                  o.status = ST_INVALID;
               else if (r.data_size > effective_capacity())
                  o.status = ST_TOO_SMALL;
               else if (last_seq == '1)
                  o.status = ST_OVERFLOW;
               else begin
                  meta_size[fill_slot]  = r.data_size[CAP_W-1:0];
                  meta_seq[fill_slot]   = last_seq + 1;
                  meta_stamp[fill_slot] = r.stamp;
                  live_slot   = fill_slot;
                  published   = 1'b1;
                  writer_open = 1'b0;
               end
            end
            CMD_CANCEL: begin
               if (!writer_open) o.status = ST_INVALID;
               else writer_open = 1'b0;
            end
            CMD_ACQUIRE, CMD_QUERY: begin
               if (!published) begin
                  o.status = ST_EMPTY;
               end else if (r.cmd == CMD_ACQUIRE && lease_open[live_slot]) begin
                  o.status = ST_BUSY;
               end else begin
                  if (r.cmd == CMD_ACQUIRE) begin
                     lease_open[live_slot] = 1'b1;
                     o.granted = live_slot;
                  end
                  o.size  = meta_size[live_slot];
                  o.seq   = meta_seq[live_slot];
                  o.stamp = meta_stamp[live_slot];
               end
            end
            CMD_RELEASE: begin
               if (!lease_open[ls] || r.data_size != DSIZE_W'(meta_size[ls]) ||
                   r.lease_sequence != meta_seq[ls] || r.stamp != meta_stamp[ls])
                  o.status = ST_INVALID;
               else
                  lease_open[ls] = 1'b0;
            end
            default: o.status = ST_INVALID;
         endcase
      end
      return o;
   endfunction

   function automatic outcome_type outcome(input status_type st, input logic g,
                                           input logic [CAP_W-1:0] sz,
                                           input logic [SEQ_W-1:0] sq,
                                           input logic [STAMP_W-1:0] sp);
      outcome_type o;
      o.status  = st;
      o.granted = g;
      o.size    = sz;
      o.seq     = sq;
      o.stamp   = sp;
      return o;
   endfunction

   function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                   input logic [DSIZE_W-1:0] dsize,
                                   input logic [STAMP_W-1:0] stamp,
                                   input logic lslot, input logic [SEQ_W-1:0] lseq,
                                   input bit typed, input outcome_type want);
      stim_row_type row;
      row.req   = '{cmd, dsize, stamp, lslot, lseq};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // one request; the predicted (or tabled) result is queued on acceptance
   task automatic send_request(input req_type r, input bit typed,
                               input outcome_type want);
      outcome_type predicted;
      if (idle_on && $urandom_range(99) < 38) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start              <= 1'b1;
      req_cmd            <= r.cmd;
      req_data_size      <= r.data_size;
      req_stamp          <= r.stamp;
      req_lease_slot     <= r.lease_slot;
      req_lease_sequence <= r.lease_sequence;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = snapshot_outcome(r);
      awaited_outcomes.push_back(typed ? want : predicted);
   endtask

   // stop sending and let every outstanding result come back
   task automatic settle();
      start <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [APB_AW-1:0] addr,
                             input logic [APB_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (wr)
         apply_register_write(addr, data);
      else
         report_field("prdata", {{(APB_DW-CAP_W){1'b0}}, capacity_reg}, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_capacity(input logic [APB_DW-1:0] data);
      csr_access(1'b1, CAPACITY_ADDR, data);
      csr_access(1'b0, CAPACITY_ADDR, '0);
   endtask

   // cancel the open write and return every lease so a capacity write lands
   task automatic close_open_work();
      req_type r;
      if (writer_open) begin
         r = '0;
         r.cmd = CMD_CANCEL;
         send_request(r, 1'b0, '0);
      end
      for (int s = 0; s < 2; s++) begin
         if (lease_open[s]) begin
            r = '{CMD_RELEASE, DSIZE_W'(meta_size[s]), meta_stamp[s], s[0], meta_seq[s]};
            send_request(r, 1'b0, '0);
         end
      end
   endtask

   // mostly well-formed writer and reader traffic, some noise and bad releases
   function automatic req_type make_request();
      req_type              r;
      int unsigned          roll;
      int unsigned          bitpos;
      logic [DSIZE_W-1:0]   cap_eff;
      logic                 s;
      r.cmd            = $urandom;
      r.data_size      = $urandom;
      r.stamp          = $urandom;
      r.lease_slot     = $urandom;
      r.lease_sequence = $urandom;
      roll    = $urandom_range(99);
      cap_eff = effective_capacity();
      if (roll < 15) begin
         return r;
      end else if (roll < 55) begin
         if (!writer_open) begin
            r.cmd = CMD_BEGIN;
         end else if ($urandom_range(9) < 8) begin
            r.cmd = CMD_PUBLISH;
            if ($urandom_range(9) < 8)
               r.data_size = DSIZE_W'($urandom_range(cap_eff, 0));
            else
               r.data_size = cap_eff + DSIZE_W'($urandom_range(3, 1));
         end else begin
            r.cmd = CMD_CANCEL;
         end
      end else if (roll < 75) begin
         r.cmd = ($urandom_range(3) == 0) ? CMD_QUERY : CMD_ACQUIRE;
      end else begin
         r.cmd = CMD_RELEASE;
         if (lease_open[0] && lease_open[1]) s = $urandom;
         else if (lease_open[1]) s = 1'b1;
         else if (lease_open[0]) s = 1'b0;
         else s = $urandom;
         r.lease_slot     = s;
         r.data_size      = DSIZE_W'(meta_size[s]);
         r.lease_sequence = meta_seq[s];
         r.stamp          = meta_stamp[s];
         // occasionally break the lease identity
         if ($urandom_range(9) == 0) begin
            bitpos = $urandom_range(15);
            case ($urandom_range(2))
               0: r.data_size[bitpos] = ~r.data_size[bitpos];
               1: r.lease_sequence[bitpos] = ~r.lease_sequence[bitpos];
               default: r.stamp[bitpos + 16] = ~r.stamp[bitpos + 16];
            endcase
         end
      end
      return r;
   endfunction

   initial begin
      logic [APB_DW-1:0] phase_caps [7];
      phase_caps = '{32'd1, 32'd4096, 32'd4097, 32'd2, 32'd0, 32'hFFFF_E005, 32'd8191};
      capacity_reg = '0;
      clear_snapshot_state();

      // everything answers not initialized until a capacity is written
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_NOT_INIT, 0, 0, 0, 0));
      add_row(CMD_PUBLISH, 16'd16, '1, 1'b0, '0, 1'b1, outcome(ST_NOT_INIT, 0, 0, 0, 0));
      add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b1, outcome(ST_NOT_INIT, 0, 0, 0, 0));
      add_row(CMD_SPARE_7, '1, '1, 1'b1, '1, 1'b1, outcome(ST_NOT_INIT, 0, 0, 0, 0));
      // nothing published yet, no writer, unknown commands, stray release
      add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b1, outcome(ST_EMPTY, 0, 0, 0, 0));
      add_row(CMD_ACQUIRE, '0, '0, 1'b0, '0, 1'b1, outcome(ST_EMPTY, 0, 0, 0, 0));
      add_row(CMD_PUBLISH, '0, '0, 1'b0, '0, 1'b1, outcome(ST_INVALID, 0, 0, 0, 0));
      add_row(CMD_CANCEL, '0, '0, 1'b0, '0, 1'b1, outcome(ST_INVALID, 0, 0, 0, 0));
      add_row(CMD_SPARE_6, '0, '0, 1'b0, '0, 1'b1, outcome(ST_INVALID, 0, 0, 0, 0));
      add_row(CMD_RELEASE, '1, '1, 1'b1, '1, 1'b1, outcome(ST_INVALID, 0, 0, 0, 0));
      // first write goes to slot 0; oversize publishes keep the write open
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 0, 0, 0, 0));
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_BUSY, 0, 0, 0, 0));
      add_row(CMD_PUBLISH, 16'd4097, '0, 1'b0, '0, 1'b1, outcome(ST_TOO_SMALL, 0, 0, 0, 0));
      add_row(CMD_PUBLISH, '1, '0, 1'b0, '0, 1'b1, outcome(ST_TOO_SMALL, 0, 0, 0, 0));
      add_row(CMD_PUBLISH, 16'd4096, '1, 1'b0, '0, 1'b1, outcome(ST_OK, 0, 0, 0, 0));
      add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 0, 13'd4096, 1, '1));
      add_row(CMD_ACQUIRE, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 0, 13'd4096, 1, '1));
      add_row(CMD_ACQUIRE, '0, '0, 1'b0, '0, 1'b1, outcome(ST_BUSY, 0, 0, 0, 0));
      // second slot, cancel, then a publish that flips the active slot
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 1, 0, 0, 0));
      add_row(CMD_CANCEL, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 0, 0, 0, 0));
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_OK, 1, 0, 0, 0));
      add_row(CMD_PUBLISH, '0, '0, 1'b0, '0, 1'b0, '0);
      // inactive slot still leased; wrong stamp keeps the lease
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b1, outcome(ST_BUSY, 0, 0, 0, 0));
      add_row(CMD_RELEASE, 16'd4096, '0, 1'b0, 32'd1, 1'b1,
              outcome(ST_INVALID, 0, 0, 0, 0));
      add_row(CMD_RELEASE, 16'd4096, '1, 1'b0, 32'd1, 1'b1, outcome(ST_OK, 0, 0, 0, 0));
      add_row(CMD_BEGIN, '0, '0, 1'b0, '0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (i == 4) begin
            settle();
            program_capacity('0);
            program_capacity(32'd8191);
         end
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      // writes with the writer open, and to the unused address, are dropped
      settle();
      program_capacity(32'd100);
      csr_access(1'b1, SPARE_ADDR, 32'd7);
      csr_access(1'b0, CAPACITY_ADDR, '0);

      // random traffic, one capacity per phase; sequence wrap needs 2^32
      // publishes and is out of reach here
      for (int p = 0; p < 7; p++) begin
         if (p != 3) close_open_work();
         settle();
         program_capacity((p == 4) ? 32'($urandom_range(8191, 1)) : phase_caps[p]);
         idle_on = (p != 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2) settle();
            send_request(make_request(), 1'b0, '0);
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("double_buffer_snapshot_manager verification clean");
      else
         $display("double_buffer_snapshot_manager verification failed");
      $finish;
   end

endmodule
